[hdl/mp4ms_pkg.sv]
`default_nettype none
package mp4ms_pkg;

  localparam int LENGTH_BITS_DEFAULT = 31;
  localparam int RUN_MAX = 8;
  localparam int RUN_IDX_BITS = $clog2(RUN_MAX);
  localparam int SIZE_CMP_BITS = 33;

  localparam logic [1:0] REG_CONTAINER_TYPE = 2'd0;
  localparam logic [1:0] REG_STRIP_FIRST    = 2'd1;
  localparam logic [1:0] REG_STRIP_SECOND   = 2'd2;
  localparam logic [1:0] REG_REPLACEMENT    = 2'd3;

  localparam logic [31:0] FOURCC_MOOV = 32'h6d6f6f76;
  localparam logic [31:0] FOURCC_META = 32'h6d657461;
  localparam logic [31:0] FOURCC_UDTA = 32'h75647461;
  localparam logic [31:0] FOURCC_FREE = 32'h66726565;

  localparam logic [31:0] MIN_BOX_SIZE = 32'd8;

  typedef struct packed {
    logic [30:0] buffer_length;
    logic        last_of_buffer;
    logic        first_of_buffer;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [RUN_MAX-1:0][7:0]  bytes;
    logic [RUN_IDX_BITS-1:0]  last_idx;
    logic                     parse_error;
    logic                     end_of_buffer;
  } run_t;

endpackage
`default_nettype wire

[hdl/mp4ms_in_stage.sv]
`default_nettype none
module mp4ms_in_stage (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_valid,
  output logic                      s_ready,
  input  wire mp4ms_pkg::in_item_t  s_item,
  output logic                      item_valid,
  output mp4ms_pkg::in_item_t       item,
  input  wire logic                 item_take
);

  assign s_ready = !item_valid || item_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_ready) begin
      item_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      item <= s_item;
    end
  end

endmodule
`default_nettype wire

[hdl/mp4ms_parser.sv]
`default_nettype none
module mp4ms_parser #(
  parameter int LENGTH_BITS = mp4ms_pkg::LENGTH_BITS_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [31:0]          cfg_data,
  input  wire logic                 item_valid,
  input  wire mp4ms_pkg::in_item_t  item,
  input  wire logic                 run_free,
  output logic                      item_take,
  output logic                      run_load,
  output mp4ms_pkg::run_t           run
);

  localparam int W1 = LENGTH_BITS + 1;
  localparam int CW = mp4ms_pkg::SIZE_CMP_BITS;
  localparam int RB = mp4ms_pkg::RUN_IDX_BITS;

  logic [31:0] container_type, strip_type_first, strip_type_second, replacement_type;

  logic [LENGTH_BITS-1:0] byte_position, byte_position_next;
  logic [LENGTH_BITS-1:0] stored_length, stored_length_next;
  logic [55:0]            top_header_shift, top_header_shift_next;
  logic [31:0]            top_box_remaining, top_box_remaining_next;
  logic                   inside_container, inside_container_next;
  logic [31:0]            container_remaining, container_remaining_next;
  logic [7:0]             child_header_hold [mp4ms_pkg::RUN_MAX];
  logic [RB-1:0]          header_byte_count, header_byte_count_next;
  logic [31:0]            child_remaining, child_remaining_next;
  logic                   zeroing_payload, zeroing_payload_next;
  logic                   error_latched, error_latched_next;

  logic [LENGTH_BITS-1:0] pos_e, stored_e, start_pos, room, len_in;
  logic [31:0]            len32;
  logic [31:0]            box_size, box_type;
  logic                   emit, hold_we, first_b, last_b;
  logic [7:0]             b;

  assign first_b   = item.first_of_buffer;
  assign last_b    = item.last_of_buffer;
  assign b         = item.data_byte;
  assign len32     = {1'b0, item.buffer_length};
  assign len_in    = len32[LENGTH_BITS-1:0];
  assign item_take = item_valid && run_free;
  assign run_load  = item_take && emit;

  function automatic logic [31:0] MIN_SIZE();
    return mp4ms_pkg::MIN_BOX_SIZE;
  endfunction

  always_comb begin
    pos_e    = first_b ? '0 : byte_position;
    stored_e = first_b ? len_in : stored_length;

    byte_position_next       = pos_e;
    stored_length_next       = stored_e;
    top_header_shift_next    = top_header_shift;
    top_box_remaining_next   = first_b ? '0 : top_box_remaining;
    inside_container_next    = first_b ? 1'b0 : inside_container;
    container_remaining_next = first_b ? '0 : container_remaining;
    header_byte_count_next   = first_b ? '0 : header_byte_count;
    child_remaining_next     = first_b ? '0 : child_remaining;
    zeroing_payload_next     = first_b ? 1'b0 : zeroing_payload;
    error_latched_next       = first_b ? 1'b0 : error_latched;

    hold_we   = 1'b0;
    emit      = 1'b0;
    box_size  = '0;
    box_type  = '0;
    start_pos = '0;
    room      = '0;

    for (int i = 0; i < mp4ms_pkg::RUN_MAX; i++) begin
      run.bytes[i] = (RB'(i) == header_byte_count_next) ? b : child_header_hold[i];
    end
    run.last_idx = header_byte_count_next;

    if (error_latched_next) begin
      emit = 1'b1;
      if (inside_container_next && header_byte_count_next != '0) begin
        header_byte_count_next = '0;
      end else begin
        run.bytes[0] = b;
        run.last_idx = '0;
      end
    end else if (inside_container_next) begin
      if (child_remaining_next != '0) begin
        emit = 1'b1;
        run.bytes[0] = zeroing_payload_next ? 8'd0 : b;
        run.last_idx = '0;
        child_remaining_next     = child_remaining_next - 32'd1;
        container_remaining_next = container_remaining_next - 32'd1;
        if (child_remaining_next == '0) begin
          zeroing_payload_next = 1'b0;
        end
      end else if (header_byte_count_next == '0 && container_remaining_next < MIN_SIZE()) begin
        emit = 1'b1;
        error_latched_next = 1'b1;
        run.bytes[0] = b;
        run.last_idx = '0;
      end else begin
        hold_we = 1'b1;
        container_remaining_next = container_remaining_next - 32'd1;
        if (header_byte_count_next == RB'(mp4ms_pkg::RUN_MAX - 1)) begin
          emit = 1'b1;
          box_size = {child_header_hold[0], child_header_hold[1],
                      child_header_hold[2], child_header_hold[3]};
          box_type = {child_header_hold[4], child_header_hold[5], child_header_hold[6], b};
          header_byte_count_next = '0;
          if (box_size < MIN_SIZE() ||
              CW'(box_size) > CW'(container_remaining_next) + CW'(MIN_SIZE())) begin
            error_latched_next = 1'b1;
          end else begin
            if (box_type == strip_type_first || box_type == strip_type_second) begin
              run.bytes[4] = replacement_type[31:24];
              run.bytes[5] = replacement_type[23:16];
              run.bytes[6] = replacement_type[15:8];
              run.bytes[7] = replacement_type[7:0];
              zeroing_payload_next = 1'b1;
            end
            child_remaining_next = box_size - MIN_SIZE();
            if (child_remaining_next == '0) begin
              zeroing_payload_next = 1'b0;
            end
          end
        end else begin
          header_byte_count_next = header_byte_count_next + RB'(1);
        end
      end
      if (!error_latched_next && container_remaining_next == '0 &&
          header_byte_count_next == '0 && child_remaining_next == '0) begin
        inside_container_next = 1'b0;
      end
    end else begin
      emit = 1'b1;
      run.bytes[0] = b;
      run.last_idx = '0;
      if (top_box_remaining_next != '0) begin
        top_box_remaining_next = top_box_remaining_next - 32'd1;
      end else if (header_byte_count_next != '0 ||
                   W1'(stored_e) >= W1'(pos_e) + W1'(9)) begin
        top_header_shift_next = {top_header_shift[47:0], b};
        if (header_byte_count_next == RB'(mp4ms_pkg::RUN_MAX - 1)) begin
          header_byte_count_next = '0;
          box_size  = top_header_shift[55:24];
          box_type  = {top_header_shift[23:0], b};
          start_pos = (pos_e >= LENGTH_BITS'(7)) ? pos_e - LENGTH_BITS'(7) : '0;
          room      = (stored_e > start_pos) ? stored_e - start_pos : '0;
          if (box_size < MIN_SIZE() || CW'(box_size) > CW'(room)) begin
            error_latched_next = 1'b1;
          end else if (box_type == container_type) begin
            container_remaining_next = box_size - MIN_SIZE();
            inside_container_next    = (container_remaining_next != '0);
          end else begin
            top_box_remaining_next = box_size - MIN_SIZE();
          end
        end else begin
          header_byte_count_next = header_byte_count_next + RB'(1);
        end
      end
    end

    if (last_b) begin
      if (inside_container_next && header_byte_count_next != '0) begin
        emit = 1'b1;
        run.last_idx = header_byte_count_next - RB'(1);
      end
      top_box_remaining_next   = '0;
      inside_container_next    = 1'b0;
      container_remaining_next = '0;
      header_byte_count_next   = '0;
      child_remaining_next     = '0;
      zeroing_payload_next     = 1'b0;
      byte_position_next       = stored_e;
    end else if (pos_e != {LENGTH_BITS{1'b1}}) begin
      byte_position_next = pos_e + LENGTH_BITS'(1);
    end

    run.parse_error   = error_latched_next;
    run.end_of_buffer = last_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      container_type    <= mp4ms_pkg::FOURCC_MOOV;
      strip_type_first  <= mp4ms_pkg::FOURCC_META;
      strip_type_second <= mp4ms_pkg::FOURCC_UDTA;
      replacement_type  <= mp4ms_pkg::FOURCC_FREE;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mp4ms_pkg::REG_CONTAINER_TYPE: container_type    <= cfg_data;
        mp4ms_pkg::REG_STRIP_FIRST:    strip_type_first  <= cfg_data;
        mp4ms_pkg::REG_STRIP_SECOND:   strip_type_second <= cfg_data;
        mp4ms_pkg::REG_REPLACEMENT:    replacement_type  <= cfg_data;
        default:                       container_type    <= container_type;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position       <= '0;
      stored_length       <= '0;
      top_box_remaining   <= '0;
      inside_container    <= 1'b0;
      container_remaining <= '0;
      header_byte_count   <= '0;
      child_remaining     <= '0;
      zeroing_payload     <= 1'b0;
      error_latched       <= 1'b0;
    end else if (item_take) begin
      byte_position       <= byte_position_next;
      stored_length       <= stored_length_next;
      top_box_remaining   <= top_box_remaining_next;
      inside_container    <= inside_container_next;
      container_remaining <= container_remaining_next;
      header_byte_count   <= header_byte_count_next;
      child_remaining     <= child_remaining_next;
      zeroing_payload     <= zeroing_payload_next;
      error_latched       <= error_latched_next;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      top_header_shift <= top_header_shift_next;
      if (hold_we) begin
        child_header_hold[run.last_idx] <= b;
      end
    end
  end

endmodule
`default_nettype wire

[hdl/mp4ms_out_ser.sv]
`default_nettype none
module mp4ms_out_ser (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             run_load,
  input  wire mp4ms_pkg::run_t  run,
  output logic                  run_free,
  output logic                  m_valid,
  input  wire logic             m_ready,
  output logic [7:0]            m_byte,
  output logic                  m_last,
  output logic [1:0]            m_flags
);

  mp4ms_pkg::run_t                      held;
  logic [mp4ms_pkg::RUN_IDX_BITS-1:0]   idx;
  logic                                 at_end;

  assign at_end   = (idx == held.last_idx);
  assign run_free = !m_valid || (m_ready && at_end);
  assign m_byte   = held.bytes[idx];
  assign m_last   = at_end;
  assign m_flags  = {held.end_of_buffer && at_end, held.parse_error};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
      idx     <= '0;
    end else if (run_load) begin
      m_valid <= 1'b1;
      idx     <= '0;
    end else if (m_valid && m_ready) begin
      if (at_end) begin
        m_valid <= 1'b0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (run_load) begin
      held <= run;
    end
  end

endmodule
`default_nettype wire

[hdl/mp4_metadata_box_scrubber_top.sv]
`default_nettype none
// MP4 metadata box scrubber. Takes one buffer byte per request and walks the
// top-level boxes; children of the container box whose type matches either strip
// type are re-typed to the replacement type and their payload is zeroed. A plain
// byte passes through the input register and then the output run register, and
// the block sustains one byte per cycle while m_tready is high and no run is
// draining. Bytes of a child header are held and produce no output
// until the eighth arrives; that byte then yields a run of eight output bytes,
// which the output serialiser drains one per cycle while m_tready is high, and
// the input stalls meanwhile. A last byte arriving mid-header flushes
// the held bytes as one run. Size errors latch and are reported on every output
// until the next first byte; after an error all bytes pass unchanged. Config
// writes are always accepted and must only be made while the block is idle.
module mp4_metadata_box_scrubber_top #(
  parameter int LENGTH_BITS = mp4ms_pkg::LENGTH_BITS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // data_byte, buffer_length, zero pad
  input  wire logic        s_tuser,   // first_of_buffer
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // out_byte
  output logic [1:0]       m_tuser,   // parse_error, end_of_buffer
  output logic             m_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  mp4ms_pkg::in_item_t s_item, item;
  mp4ms_pkg::run_t     run;
  logic                item_valid, item_take, run_free, run_load;

  assign cfg_ready = 1'b1;

  assign s_item.data_byte       = s_tdata[7:0];
  assign s_item.buffer_length   = s_tdata[38:8];
  assign s_item.first_of_buffer = s_tuser;
  assign s_item.last_of_buffer  = s_tlast;

  mp4ms_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .s_valid    (s_tvalid),
    .s_ready    (s_tready),
    .s_item     (s_item),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  mp4ms_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item       (item),
    .run_free   (run_free),
    .item_take  (item_take),
    .run_load   (run_load),
    .run        (run)
  );

  mp4ms_out_ser u_out_ser (
    .clk      (clk),
    .rst      (rst),
    .run_load (run_load),
    .run      (run),
    .run_free (run_free),
    .m_valid  (m_tvalid),
    .m_ready  (m_tready),
    .m_byte   (m_tdata),
    .m_last   (m_tlast),
    .m_flags  (m_tuser)
  );

endmodule
`default_nettype wire
